[src/lrpw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpw_pkg
// Shared types and constants of the line raster pixel writer: item layouts,
// configuration register set, register indexes and fixed widths.
// ----------------------------------------------------------------------------
package lrpw_pkg;

    localparam int COORD_W    = 16;
    localparam int HEIGHT_W   = 16;
    localparam int DELTA_W    = COORD_W + 1;
    localparam int ERR_W      = COORD_W + 3;
    localparam int WIN_W      = 12;
    localparam int STRIDE_W   = 14;
    localparam int BPP_W      = 6;
    localparam int ADDR_W     = 26;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic              OP_START    = 1'b0;
    localparam logic              OP_STEP     = 1'b1;
    localparam logic [BYTE_W-1:0] COLOUR_FULL = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_WIDTH   = 3'd0,
        CFG_WINDOW_HEIGHT  = 3'd1,
        CFG_ROW_STRIDE     = 3'd2,
        CFG_BITS_PER_PIXEL = 3'd3,
        CFG_DEPTH_OFFSET   = 3'd4,
        CFG_RED_OFFSET     = 3'd5,
        CFG_GREEN_OFFSET   = 3'd6,
        CFG_BLUE_OFFSET    = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic                       operation;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
        logic signed [HEIGHT_W-1:0] point_height;
    } t_in_item;

    typedef struct packed {
        logic                      pixel_valid;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic                      write_enable;
        logic [ADDR_W-1:0]         byte_address;
        logic [BYTE_W-1:0]         blue_byte;
        logic [BYTE_W-1:0]         green_byte;
        logic [BYTE_W-1:0]         red_byte;
        logic                      line_done;
    } t_out_item;

    typedef struct packed {
        logic [WIN_W-1:0]           window_width;
        logic [WIN_W-1:0]           window_height;
        logic [STRIDE_W-1:0]        row_stride;
        logic [BPP_W-1:0]           bits_per_pixel;
        logic signed [HEIGHT_W-1:0] depth_offset;
        logic [BYTE_W-1:0]          red_offset;
        logic [BYTE_W-1:0]          green_offset;
        logic [BYTE_W-1:0]          blue_offset;
    } t_cfg;

    // Position stage result handed to the pixel stage.
    typedef struct packed {
        logic                      pixel_valid;
        logic signed [COORD_W-1:0] pixel_x;
        logic signed [COORD_W-1:0] pixel_y;
        logic [1:0]                colour_select;
        logic                      line_done;
    } t_step;

endpackage
`default_nettype wire

[src/lrpw_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpw_cfg_regs
// Configuration register file: window, framebuffer layout and colour offsets.
// ----------------------------------------------------------------------------
module lrpw_cfg_regs
    import lrpw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_width   <= WIN_W'(1024);
            r_cfg.window_height  <= WIN_W'(768);
            r_cfg.row_stride     <= STRIDE_W'(4096);
            r_cfg.bits_per_pixel <= BPP_W'(32);
            r_cfg.depth_offset   <= '0;
            r_cfg.red_offset     <= '0;
            r_cfg.green_offset   <= '0;
            r_cfg.blue_offset    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_WINDOW_WIDTH:   r_cfg.window_width   <= i_cfg_data[WIN_W-1:0];
                CFG_WINDOW_HEIGHT:  r_cfg.window_height  <= i_cfg_data[WIN_W-1:0];
                CFG_ROW_STRIDE:     r_cfg.row_stride     <= i_cfg_data[STRIDE_W-1:0];
                CFG_BITS_PER_PIXEL: r_cfg.bits_per_pixel <= i_cfg_data[BPP_W-1:0];
                CFG_DEPTH_OFFSET:   r_cfg.depth_offset   <= i_cfg_data[HEIGHT_W-1:0];
                CFG_RED_OFFSET:     r_cfg.red_offset     <= i_cfg_data[BYTE_W-1:0];
                CFG_GREEN_OFFSET:   r_cfg.green_offset   <= i_cfg_data[BYTE_W-1:0];
                CFG_BLUE_OFFSET:    r_cfg.blue_offset    <= i_cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[src/lrpw_stepper.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpw_stepper
// Line state and Bresenham step: loads a line on a start item, advances one
// pixel on a step item and registers the new position for the pixel stage.
// ----------------------------------------------------------------------------
module lrpw_stepper
    import lrpw_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire t_in_item                   i_in_item,
    input  wire logic signed [HEIGHT_W-1:0] i_depth_offset,
    output logic                            o_s1_valid,
    output t_step                           o_s1,
    input  wire logic                       i_s1_ready
);

    logic signed [COORD_W-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [DELTA_W-1:0]        r_dx, r_dy;
    logic                      r_neg_x, r_neg_y;
    logic signed [ERR_W-1:0]   r_err;
    logic [1:0]                r_colour;
    logic                      r_line_active;
    logic                      r_s1_valid;
    t_step                     r_s1;

    logic signed [COORD_W-1:0] n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic [DELTA_W-1:0]        n_dx, n_dy;
    logic                      n_neg_x, n_neg_y;
    logic signed [ERR_W-1:0]   n_err;
    logic [1:0]                n_colour;
    logic                      n_line_active;
    t_step                     n_s1;

    logic                      w_accept;
    logic signed [DELTA_W-1:0] w_dx_raw, w_dy_raw;
    logic [DELTA_W-1:0]        w_dx_abs, w_dy_abs;
    logic signed [HEIGHT_W:0]  w_hd;
    logic                      w_h_nz;
    logic signed [ERR_W-1:0]   w_dx_e, w_dy_e;
    logic                      w_move_x, w_move_y;

    assign o_in_ready = !r_s1_valid || i_s1_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        w_dx_raw = $signed({i_in_item.end_x[COORD_W-1], i_in_item.end_x})
                 - $signed({i_in_item.start_x[COORD_W-1], i_in_item.start_x});
        w_dy_raw = $signed({i_in_item.end_y[COORD_W-1], i_in_item.end_y})
                 - $signed({i_in_item.start_y[COORD_W-1], i_in_item.start_y});
        w_dx_abs = w_dx_raw[DELTA_W-1] ? DELTA_W'(-w_dx_raw) : DELTA_W'(w_dx_raw);
        w_dy_abs = w_dy_raw[DELTA_W-1] ? DELTA_W'(-w_dy_raw) : DELTA_W'(w_dy_raw);
        w_hd     = $signed({i_in_item.point_height[HEIGHT_W-1], i_in_item.point_height})
                 + $signed({i_depth_offset[HEIGHT_W-1], i_depth_offset});
        w_h_nz   = (i_in_item.point_height != '0);

        w_dx_e   = $signed(ERR_W'(r_dx));
        w_dy_e   = $signed(ERR_W'(r_dy));
        w_move_x = (r_err >= -w_dx_e);
        w_move_y = (r_err <= w_dy_e);

        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_tgt_x       = r_tgt_x;
        n_tgt_y       = r_tgt_y;
        n_dx          = r_dx;
        n_dy          = r_dy;
        n_neg_x       = r_neg_x;
        n_neg_y       = r_neg_y;
        n_err         = r_err;
        n_colour      = r_colour;
        n_line_active = r_line_active;
        n_s1          = '0;

        if (i_in_item.operation == OP_START) begin
            n_cur_x = i_in_item.start_x;
            n_cur_y = i_in_item.start_y;
            n_tgt_x = i_in_item.end_x;
            n_tgt_y = i_in_item.end_y;
            n_dx    = w_dx_abs;
            n_dy    = w_dy_abs;
            n_neg_x = !(i_in_item.start_x < i_in_item.end_x);
            n_neg_y = !(i_in_item.start_y < i_in_item.end_y);
            n_err   = (w_dx_abs > w_dy_abs) ? $signed(ERR_W'(w_dx_abs >> 1))
                                            : -$signed(ERR_W'(w_dy_abs >> 1));
            if (w_h_nz && !w_hd[HEIGHT_W] && (w_hd != '0)) begin
                n_colour = 2'b01;
            end else if (w_h_nz && w_hd[HEIGHT_W]) begin
                n_colour = 2'b10;
            end else begin
                n_colour = 2'b00;
            end
            n_line_active = (n_cur_x != n_tgt_x) || (n_cur_y != n_tgt_y);
        end else if (r_line_active) begin
            if (w_move_x) begin
                n_cur_x = r_cur_x + (r_neg_x ? {COORD_W{1'b1}} : COORD_W'(1));
            end
            if (w_move_y) begin
                n_cur_y = r_cur_y + (r_neg_y ? {COORD_W{1'b1}} : COORD_W'(1));
            end
            n_err = r_err - (w_move_x ? w_dy_e : '0) + (w_move_y ? w_dx_e : '0);
            n_line_active = (n_cur_x != n_tgt_x) || (n_cur_y != n_tgt_y);
            n_s1.pixel_valid   = 1'b1;
            n_s1.colour_select = r_colour;
        end

        n_s1.pixel_x   = n_cur_x;
        n_s1.pixel_y   = n_cur_y;
        n_s1.line_done = (n_cur_x == n_tgt_x) && (n_cur_y == n_tgt_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_tgt_x       <= '0;
            r_tgt_y       <= '0;
            r_dx          <= '0;
            r_dy          <= '0;
            r_neg_x       <= 1'b0;
            r_neg_y       <= 1'b0;
            r_err         <= '0;
            r_colour      <= '0;
            r_line_active <= 1'b0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cur_x       <= n_cur_x;
                r_cur_y       <= n_cur_y;
                r_tgt_x       <= n_tgt_x;
                r_tgt_y       <= n_tgt_y;
                r_dx          <= n_dx;
                r_dy          <= n_dy;
                r_neg_x       <= n_neg_x;
                r_neg_y       <= n_neg_y;
                r_err         <= n_err;
                r_colour      <= n_colour;
                r_line_active <= n_line_active;
                r_s1_valid    <= 1'b1;
            end else if (i_s1_ready) begin
                r_s1_valid    <= 1'b0;
            end
        end
    end

    // Payload only: valid bit qualifies it.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

`ifndef SYNTHESIS
    // An active line never sits on its endpoint.
    a_active_not_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line_active |-> (r_cur_x != r_tgt_x) || (r_cur_y != r_tgt_y))
        else $error("line active while at endpoint");
`endif

endmodule
`default_nettype wire

[src/lrpw_pixel_out.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lrpw_pixel_out
// Pixel stage: window test, framebuffer byte address and colour bytes,
// held in the output register until the receiver takes the item.
// ----------------------------------------------------------------------------
module lrpw_pixel_out
    import lrpw_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_s1_valid,
    input  wire t_step i_s1,
    output logic      o_s1_ready,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  wire logic i_out_ready
);

    logic      r_out_valid;
    t_out_item r_out_item;
    t_out_item n_out_item;

    logic                          w_x_in, w_y_in, w_we;
    logic [ADDR_W-1:0]             w_row_addr;
    logic [WIN_W+BPP_W-1:0]        w_bit_off;

    assign o_s1_ready = !r_out_valid || i_out_ready;

    always_comb begin
        w_x_in = !i_s1.pixel_x[COORD_W-1] && (i_s1.pixel_x != '0)
              && (i_s1.pixel_x < $signed(COORD_W'(i_cfg.window_width)));
        w_y_in = !i_s1.pixel_y[COORD_W-1] && (i_s1.pixel_y != '0)
              && (i_s1.pixel_y < $signed(COORD_W'(i_cfg.window_height)));
        w_we   = i_s1.pixel_valid && w_x_in && w_y_in;

        w_row_addr = ADDR_W'(i_s1.pixel_y[WIN_W-1:0]) * ADDR_W'(i_cfg.row_stride);
        w_bit_off  = (WIN_W+BPP_W)'(i_s1.pixel_x[WIN_W-1:0])
                   * (WIN_W+BPP_W)'(i_cfg.bits_per_pixel);

        n_out_item              = '0;
        n_out_item.pixel_valid  = i_s1.pixel_valid;
        n_out_item.pixel_x      = i_s1.pixel_x;
        n_out_item.pixel_y      = i_s1.pixel_y;
        n_out_item.line_done    = i_s1.line_done;
        n_out_item.write_enable = w_we;
        if (w_we) begin
            n_out_item.byte_address = w_row_addr + ADDR_W'(w_bit_off >> 3);
        end
        if (i_s1.pixel_valid) begin
            n_out_item.red_byte   = COLOUR_FULL + i_cfg.red_offset;
            n_out_item.green_byte = (i_s1.colour_select[0] ? COLOUR_FULL : '0)
                                  + i_cfg.green_offset;
            n_out_item.blue_byte  = (i_s1.colour_select[1] ? COLOUR_FULL : '0)
                                  + i_cfg.blue_offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s1_ready) begin
            r_out_valid <= i_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_ready && i_s1_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
`default_nettype wire

[src/line_raster_pixel_writer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// line_raster_pixel_writer
// Bresenham line rasterizer producing framebuffer pixel writes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item): a start item loads a
//   line and returns a non-pixel item holding the start point; each step item
//   on an active line advances one pixel and returns its coordinates, write
//   enable, byte address and colour bytes. Exactly one result item per input item.
//   Output channel (o_out_valid / i_out_ready / o_out_item).
//   Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index at the
//   clock edge; write only while no item is in flight.
//   Pipeline: two register stages (line state/position register, then pixel
//   register with the address multiply); the result passes through them in
//   that order and is held in the pixel register until the receiver takes it.
//   Throughput: one item per cycle while the receiver is ready; the error
//   update and position step are combinational, so steps follow back to back.
//   Stall: when the receiver holds i_out_ready low, the output register and
//   the position register fill, then o_in_ready drops; nothing is lost.
//   Reset: control and line-state registers return to their reset values, no
//   line is active and both channels are empty; no clearing pass is needed.
// ----------------------------------------------------------------------------
module line_raster_pixel_writer
    import lrpw_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  w_cfg;
    t_step w_s1;
    logic  w_s1_valid;
    logic  w_s1_ready;

    lrpw_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    lrpw_stepper u_stepper (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_item      (i_in_item),
        .i_depth_offset (w_cfg.depth_offset),
        .o_s1_valid     (w_s1_valid),
        .o_s1           (w_s1),
        .i_s1_ready     (w_s1_ready)
    );

    lrpw_pixel_out u_pixel_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_s1_valid  (w_s1_valid),
        .i_s1        (w_s1),
        .o_s1_ready  (w_s1_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_ready (i_out_ready)
    );

`ifndef SYNTHESIS
    a_we_needs_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.write_enable |-> o_out_item.pixel_valid)
        else $error("write enable on a non-pixel item");

    a_no_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.pixel_valid |->
            (o_out_item.byte_address == '0) && (o_out_item.red_byte == '0)
            && (o_out_item.green_byte == '0) && (o_out_item.blue_byte == '0))
        else $error("non-pixel item carries address or colour");

    a_outside_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.write_enable |-> o_out_item.byte_address == '0)
        else $error("address given for a pixel outside the window");
`endif

endmodule
`default_nettype wire
